// ----- rtl/i8gap_pkg.sv -----
// ---------------------------------------------------------------------------
// i8gap_pkg: shared types and constants
// Widths, register codes, reset values and the structs that travel
// between the accumulator chain and the scaling pipeline.
// ---------------------------------------------------------------------------
package i8gap_pkg;

  localparam int SUM_W = 13;
  localparam int CH_IDX_W = 7;
  localparam int ADDR_W = 4;

  // register index (paddr[3:2])
  localparam logic [1:0] REG_MULT    = 2'd0;
  localparam logic [1:0] REG_SHIFT   = 2'd1;
  localparam logic [1:0] REG_IN_OFF  = 2'd2;
  localparam logic [1:0] REG_OUT_OFF = 2'd3;

  localparam logic [30:0]       MULT_RST    = 31'd1786102354;
  localparam logic signed [5:0] SHIFT_RST   = -6'sd2;
  localparam logic signed [8:0] IN_OFF_RST  = 9'sd128;
  localparam logic signed [7:0] OUT_OFF_RST = -8'sd128;

  typedef struct packed {
    logic [CH_IDX_W-1:0] channel_index;
    logic                last_channel;
  } tag_t;

  typedef struct packed {
    logic [30:0]       mult;
    logic signed [5:0] shift;
    logic signed [7:0] out_off;
  } scale_cfg_t;

endpackage

// ----- rtl/i8gap_cell.sv -----
// ---------------------------------------------------------------------------
// i8gap_cell: one accumulator cell
// Holds one channel sum and loads its input sum (its neighbor's, or the new sum at the tail) on every accepted word.
// ---------------------------------------------------------------------------
module i8gap_cell import i8gap_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [SUM_W-1:0] sum_i,
  output logic signed [SUM_W-1:0] sum_o
);

  logic signed [SUM_W-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_i;
    end
  end

  assign sum_o = sum_q;

endmodule

// ----- rtl/i8gap_scale.sv -----
// ---------------------------------------------------------------------------
// i8gap_scale: requantization pipeline
// Four stages: sum capture, shift and multiply, rounding high half,
// rounding right shift with offset and clamp (output register).
// ---------------------------------------------------------------------------
module i8gap_scale import i8gap_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  scale_cfg_t              cfg_i,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [SUM_W-1:0] sum_i,
  input  tag_t                    tag_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic signed [7:0]       mean_o,
  output tag_t                    tag_o
);

  localparam logic signed [63:0] NUDGE_POS = 64'sd1073741824;
  localparam logic signed [63:0] NUDGE_NEG = -64'sd1073741823;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [SUM_W-1:0] sum1_q;
  tag_t tag1_q, tag2_q, tag3_q, tag4_q;
  logic signed [63:0] prod2_q, prod2_d;
  logic [4:0] right2_q, right3_q, right_d;
  logic signed [31:0] hi3_q, hi3_d;
  logic signed [7:0] mean4_q, mean4_d;

  assign rdy4 = !v4_q || ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign ready_o = rdy1;

  // shift and multiply
  logic signed [5:0]  shift_c;
  logic signed [6:0]  neg_sh;
  logic [4:0]         left;
  logic signed [31:0] x_ext, x_sh;

  always_comb begin
    shift_c = (cfg_i.shift < -6'sd31) ? -6'sd31 : cfg_i.shift;
    neg_sh  = -{shift_c[5], shift_c};
    left    = (shift_c > 6'sd0) ? shift_c[4:0] : 5'd0;
    right_d = (shift_c > 6'sd0) ? 5'd0 : neg_sh[4:0];
    x_ext   = 32'(sum1_q);
    x_sh    = x_ext << left;
    prod2_d = 64'(x_sh) * 64'($signed({1'b0, cfg_i.mult}));
  end

  // high half, rounded to nearest, division truncates toward zero
  logic signed [63:0] t;
  logic               fix;

  always_comb begin
    t     = prod2_q + (prod2_q[63] ? NUDGE_NEG : NUDGE_POS);
    fix   = t[63] && (|t[30:0]);
    hi3_d = $signed(t[62:31]) + $signed({31'b0, fix});
  end

  // rounding right shift, output offset, clamp
  logic [31:0]        mask, rem;
  logic [32:0]        thr;
  logic signed [32:0] q;
  logic signed [33:0] qo;

  always_comb begin
    mask = 32'((33'd1 << right3_q) - 33'd1);
    rem  = hi3_q & mask;
    thr  = {2'b0, mask[31:1]} + {32'b0, hi3_q[31]};
    q    = 33'(hi3_q >>> right3_q) + $signed({32'b0, ({1'b0, rem} > thr)});
    qo   = 34'(q) + 34'(cfg_i.out_off);
    if (qo < -34'sd128) begin
      mean4_d = -8'sd128;
    end else if (qo > 34'sd127) begin
      mean4_d = 8'sd127;
    end else begin
      mean4_d = qo[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      sum1_q <= sum_i;
      tag1_q <= tag_i;
    end
    if (rdy2 && v1_q) begin
      prod2_q  <= prod2_d;
      right2_q <= right_d;
      tag2_q   <= tag1_q;
    end
    if (rdy3 && v2_q) begin
      hi3_q    <= hi3_d;
      right3_q <= right2_q;
      tag3_q   <= tag2_q;
    end
    if (rdy4 && v3_q) begin
      mean4_q <= mean4_d;
      tag4_q  <= tag3_q;
    end
  end

  assign valid_o = v4_q;
  assign mean_o  = mean4_q;
  assign tag_o   = tag4_q;

endmodule

// ----- rtl/int8_global_average_pool_core.sv -----
// ---------------------------------------------------------------------------
// int8_global_average_pool_core: streaming int8 global average pooling
// Per-channel sums rotate through a ring of accumulator cells, one cell per
// channel; means of the last pixel go through a requantization pipeline.
// ---------------------------------------------------------------------------
// throughput: one sample per cycle while the requantization pipeline is ready, set by the single head-cell add
// words of earlier pixels give no result and are always taken at once
// reset: channel and pixel counters, pipeline valids and registers to defaults
// accumulator cells are not reset, the first pixel writes every cell
module int8_global_average_pool_core import i8gap_pkg::*; #(
  parameter int CHANNELS = 128,
  parameter int PIXELS   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic signed [7:0] sample_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [7:0] mean_value_o,
  output logic [6:0]        channel_index_o,
  output logic              last_channel_o
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW = (PIXELS > 1) ? $clog2(PIXELS) : 1;

  // configuration registers
  logic [30:0]       mult_q;
  logic signed [5:0] shift_q;
  logic signed [8:0] in_off_q;
  logic signed [7:0] out_off_q;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q    <= MULT_RST;
      shift_q   <= SHIFT_RST;
      in_off_q  <= IN_OFF_RST;
      out_off_q <= OUT_OFF_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MULT:    mult_q    <= pwdata[30:0];
        REG_SHIFT:   shift_q   <= pwdata[5:0];
        REG_IN_OFF:  in_off_q  <= pwdata[8:0];
        REG_OUT_OFF: out_off_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MULT:    prdata = {1'b0, mult_q};
      REG_SHIFT:   prdata = 32'(shift_q);
      REG_IN_OFF:  prdata = 32'(in_off_q);
      REG_OUT_OFF: prdata = 32'(out_off_q);
      default:     prdata = 32'd0;
    endcase
  end

  // position counters
  logic [CW-1:0] ch_q;
  logic [PW-1:0] pix_q;
  logic          last_pix, first_pix, ch_wrap, in_fire;
  logic          scale_ready;

  assign last_pix   = (pix_q == PW'(PIXELS - 1));
  assign first_pix  = (pix_q == '0);
  assign ch_wrap    = (ch_q == CW'(CHANNELS - 1));
  assign in_ready_o = !last_pix || scale_ready;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q  <= '0;
      pix_q <= '0;
    end else if (in_fire) begin
      if (ch_wrap) begin
        ch_q  <= '0;
        pix_q <= last_pix ? '0 : pix_q + PW'(1);
      end else begin
        ch_q <= ch_q + CW'(1);
      end
    end
  end

  // accumulator ring: cell 0 holds the current channel, new sum enters the tail
  logic signed [SUM_W-1:0] chain [CHANNELS];
  logic signed [SUM_W-1:0] new_sum;
  logic signed [9:0]       v;

  always_comb begin
    v       = 10'(sample_i) + 10'(in_off_q);
    new_sum = first_pix ? SUM_W'(v) : chain[0] + SUM_W'(v);
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    logic signed [SUM_W-1:0] cell_in;
    if (i == CHANNELS - 1) begin : g_tail
      assign cell_in = new_sum;
    end else begin : g_mid
      assign cell_in = chain[i+1];
    end
    i8gap_cell u_cell (
      .clk_i (clk_i),
      .en_i  (in_fire),
      .sum_i (cell_in),
      .sum_o (chain[i])
    );
  end

  // requantization
  scale_cfg_t  scale_cfg;
  tag_t        tag_in, tag_out;
  logic [31:0] ch_wide;

  assign ch_wide                = 32'(ch_q);
  assign tag_in.channel_index   = ch_wide[CH_IDX_W-1:0];
  assign tag_in.last_channel    = ch_wrap;
  assign scale_cfg.mult         = mult_q;
  assign scale_cfg.shift        = shift_q;
  assign scale_cfg.out_off      = out_off_q;

  i8gap_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (scale_cfg),
    .valid_i (in_valid_i && last_pix),
    .ready_o (scale_ready),
    .sum_i   (new_sum),
    .tag_i   (tag_in),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .mean_o  (mean_value_o),
    .tag_o   (tag_out)
  );

  assign channel_index_o = tag_out.channel_index;
  assign last_channel_o  = tag_out.last_channel;

endmodule
